// ===== hdl/cbfv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbfv_pkg
// Shared types and constants of the command batch frame validator.
// ----------------------------------------------------------------------------
package cbfv_pkg;

  // Fixed frame layout
  localparam int HeaderBytes     = 24;
  localparam int CommandAlign    = 8;
  localparam int MinCommandBytes = 8;
  localparam int AlignBits       = $clog2(CommandAlign);
  localparam int MinBytesW       = $clog2(MinCommandBytes + 1);
  localparam int CntProdW        = 32 + MinBytesW;
  localparam int SizeFieldW      = 32;

  // Configuration port
  localparam int CfgDataW = 64;
  localparam int CfgAddrW = 5;

  typedef enum logic [1:0] {
    RegMemorySize      = 2'd0,
    RegExpectedVersion = 2'd1,
    RegMaxBatchBytes   = 2'd2,
    RegMaxCommands     = 2'd3
  } reg_idx_e;

  localparam logic [32:0] MemorySizeRst      = 33'd65536;
  localparam logic [31:0] ExpectedVersionRst = 32'd1;
  localparam logic [31:0] MaxBatchBytesRst   = 32'd16777216;
  localparam logic [31:0] MaxCommandsRst     = 32'd4096;

  typedef enum logic {
    OpHeader = 1'b0,
    OpRegion = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    StValid       = 3'd0,
    StMisaligned  = 3'd1,
    StOutOfBounds = 3'd2,
    StBadStruct   = 3'd3,
    StSizeLimit   = 3'd4,
    StBadCount    = 3'd5,
    StBadCmdSize  = 3'd6,
    StTrailing    = 3'd7
  } status_e;

  typedef struct packed {
    logic [0:0]  operation;
    logic [31:0] header_addr;
    logic [31:0] hdr_struct_size;
    logic [31:0] hdr_version;
    logic [31:0] hdr_region_offset;
    logic [31:0] hdr_region_size;
    logic [31:0] hdr_command_count;
    logic [31:0] hdr_reserved;
    logic [63:0] region_word;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] issue_offset;
    logic [31:0] command_total;
  } out_item_t;

  typedef struct packed {
    logic [32:0] memory_size;
    logic [31:0] expected_version;
    logic [31:0] max_batch_bytes;
    logic [31:0] max_commands;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hdl/cbfv_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbfv_cfg_regs
// APB register file: memory size, version, batch byte and command limits.
// ----------------------------------------------------------------------------
module cbfv_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cbfv_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [cbfv_pkg::CfgDataW-1:0] pwdata,
  output logic      [cbfv_pkg::CfgDataW-1:0] prdata,
  output logic                               pready,
  output cbfv_pkg::cfg_t                     cfg_o
);

  cbfv_pkg::cfg_t   cfg_q, cfg_d;
  cbfv_pkg::reg_idx_e idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = cbfv_pkg::reg_idx_e'(paddr[4:3]);
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        cbfv_pkg::RegMemorySize:      cfg_d.memory_size      = pwdata[32:0];
        cbfv_pkg::RegExpectedVersion: cfg_d.expected_version = pwdata[31:0];
        cbfv_pkg::RegMaxBatchBytes:   cfg_d.max_batch_bytes  = pwdata[31:0];
        cbfv_pkg::RegMaxCommands:     cfg_d.max_commands     = pwdata[31:0];
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cbfv_pkg::RegMemorySize:      prdata = {31'd0, cfg_q.memory_size};
      cbfv_pkg::RegExpectedVersion: prdata = {32'd0, cfg_q.expected_version};
      cbfv_pkg::RegMaxBatchBytes:   prdata = {32'd0, cfg_q.max_batch_bytes};
      cbfv_pkg::RegMaxCommands:     prdata = {32'd0, cfg_q.max_commands};
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.memory_size      <= cbfv_pkg::MemorySizeRst;
      cfg_q.expected_version <= cbfv_pkg::ExpectedVersionRst;
      cfg_q.max_batch_bytes  <= cbfv_pkg::MaxBatchBytesRst;
      cfg_q.max_commands     <= cbfv_pkg::MaxCommandsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== hdl/cbfv_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbfv_in_reg
// Input register; holds one transaction until the check stage takes it.
// ----------------------------------------------------------------------------
module cbfv_in_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire cbfv_pkg::in_item_t in_data_i,
  input  wire logic               advance_i,
  output logic                    item_valid_o,
  output cbfv_pkg::in_item_t      item_o
);

  logic               valid_q, valid_d;
  cbfv_pkg::in_item_t item_q, item_d;
  logic               load;

  // Slot free, or its item leaves this cycle
  assign load       = !valid_q || advance_i;
  assign in_stall_o = !load;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d = in_valid_i;
      item_d  = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule
`default_nettype wire

// ===== hdl/cbfv_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbfv_check
// Header and command checks, batch state, and the result register.
// ----------------------------------------------------------------------------
module cbfv_check (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cbfv_pkg::cfg_t     cfg_i,
  input  wire logic               item_valid_i,
  input  wire cbfv_pkg::in_item_t item_i,
  output logic                    advance_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output cbfv_pkg::out_item_t     out_data_o
);

  // Batch state
  logic        active_q, active_d;
  logic [31:0] base_q, base_d;
  logic [31:0] rlen_q, rlen_d;
  logic [31:0] left_q, left_d;
  logic [31:0] total_q, total_d;
  logic [32:0] wpos_q, wpos_d;
  logic [32:0] ncs_q, ncs_d;

  // Result register
  logic                out_valid_q, out_valid_d;
  cbfv_pkg::out_item_t out_q, out_d;

  // Step results
  logic                emit;
  cbfv_pkg::status_e   st;
  logic [31:0]         off;
  logic [31:0]         tot;

  // Header terms
  logic [33:0]                   hdr_end, reg_end, mem_ext;
  logic [cbfv_pkg::CntProdW-1:0] cnt_bytes, rsz_ext;

  // Region terms
  logic [31:0] cmd_size;
  logic [32:0] room;
  logic [33:0] new_cur;
  logic [33:0] new_cur4;
  logic [31:0] left_dec;
  logic [31:0] cur_addr, new_addr;

  assign advance_o = item_valid_i && (!out_valid_q || !out_stall_i);

  assign mem_ext   = {1'b0, cfg_i.memory_size};
  assign hdr_end   = {2'b0, item_i.header_addr} + 34'(cbfv_pkg::HeaderBytes);
  assign reg_end   = {2'b0, item_i.hdr_region_offset} + {2'b0, item_i.hdr_region_size};
  assign cnt_bytes = cbfv_pkg::CntProdW'(item_i.hdr_command_count)
                   * cbfv_pkg::CntProdW'(cbfv_pkg::MinCommandBytes);
  assign rsz_ext   = cbfv_pkg::CntProdW'(item_i.hdr_region_size);

  assign cmd_size = item_i.region_word[cbfv_pkg::SizeFieldW-1:0];
  assign room     = {1'b0, rlen_q} - wpos_q;  // word_position == next start here
  assign new_cur  = {1'b0, wpos_q} + {2'b0, cmd_size};
  assign new_cur4 = new_cur + 34'd4;
  assign left_dec = left_q - 32'd1;
  assign cur_addr = base_q + wpos_q[31:0];
  assign new_addr = base_q + new_cur[31:0];

  always_comb begin
    emit     = 1'b0;
    st       = cbfv_pkg::StValid;
    off      = '0;
    tot      = '0;
    active_d = active_q;
    base_d   = base_q;
    rlen_d   = rlen_q;
    left_d   = left_q;
    total_d  = total_q;
    wpos_d   = wpos_q;
    ncs_d    = ncs_q;

    if (advance_o) begin
      if (item_i.operation == cbfv_pkg::OpHeader) begin
        active_d = 1'b0;
        emit     = 1'b1;
        off      = item_i.hdr_region_offset;
        if (item_i.header_addr[1:0] != 2'd0) begin
          st  = cbfv_pkg::StMisaligned;
          off = item_i.header_addr;
        end else if (hdr_end > mem_ext) begin
          st  = cbfv_pkg::StOutOfBounds;
          off = item_i.header_addr;
        end else if (item_i.hdr_struct_size != 32'(cbfv_pkg::HeaderBytes) ||
                     item_i.hdr_version != cfg_i.expected_version ||
                     item_i.hdr_reserved != 32'd0) begin
          st  = cbfv_pkg::StBadStruct;
          off = item_i.header_addr;
        end else if (item_i.hdr_region_size > cfg_i.max_batch_bytes) begin
          st = cbfv_pkg::StSizeLimit;
        end else if (item_i.hdr_region_offset[cbfv_pkg::AlignBits-1:0] != '0) begin
          st = cbfv_pkg::StMisaligned;
        end else if (reg_end > mem_ext) begin
          st = cbfv_pkg::StOutOfBounds;
        end else if (item_i.hdr_command_count > cfg_i.max_commands ||
                     cnt_bytes > rsz_ext) begin
          st = cbfv_pkg::StBadCount;
        end else if (item_i.hdr_command_count == 32'd0) begin
          st = (item_i.hdr_region_size != 32'd0) ? cbfv_pkg::StTrailing
                                                 : cbfv_pkg::StValid;
        end else begin
          // Batch opens; region words follow
          emit     = 1'b0;
          active_d = 1'b1;
          base_d   = item_i.hdr_region_offset;
          rlen_d   = item_i.hdr_region_size;
          left_d   = item_i.hdr_command_count;
          total_d  = item_i.hdr_command_count;
          wpos_d   = '0;
          ncs_d    = '0;
        end
      end else if (active_q) begin
        wpos_d = wpos_q + 33'd8;
        if (wpos_q == ncs_q) begin
          if (cmd_size < 32'(cbfv_pkg::MinCommandBytes) || {1'b0, cmd_size} > room) begin
            emit = 1'b1;
            st   = cbfv_pkg::StBadCmdSize;
            off  = cur_addr;
          end else if (cmd_size[cbfv_pkg::AlignBits-1:0] != '0) begin
            emit = 1'b1;
            st   = cbfv_pkg::StMisaligned;
            off  = cur_addr;
          end else begin
            ncs_d  = new_cur[32:0];
            left_d = left_dec;
            if (left_dec == 32'd0) begin
              emit = 1'b1;
              if (new_cur != {2'b0, rlen_q}) begin
                st  = cbfv_pkg::StTrailing;
                off = new_addr;
              end else begin
                st  = cbfv_pkg::StValid;
                off = base_q;
                tot = total_q;
              end
            end else if (new_cur4 > {2'b0, rlen_q}) begin
              // Too little room left for another size word
              emit = 1'b1;
              st   = cbfv_pkg::StBadCount;
              off  = new_addr;
            end
          end
        end
      end
      if (emit) begin
        active_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (!out_valid_q || !out_stall_i) begin
      out_valid_d         = advance_o && emit;
      out_d.status        = st;
      out_d.issue_offset  = off;
      out_d.command_total = tot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      base_q      <= '0;
      rlen_q      <= '0;
      left_q      <= '0;
      total_q     <= '0;
      wpos_q      <= '0;
      ncs_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      base_q      <= base_d;
      rlen_q      <= rlen_d;
      left_q      <= left_d;
      total_q     <= total_d;
      wpos_q      <= wpos_d;
      ncs_q       <= ncs_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== hdl/command_batch_frame_validator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// command_batch_frame_validator_unit
// Validates a command batch: header checks, then a walk over the commands.
// ----------------------------------------------------------------------------
// A header transaction (operation 0) carries the batch address and the six
// header words; it is checked in order for header alignment, header bounds,
// size/version/reserved word, region byte limit, region alignment, region
// bounds and command count. If all pass, the command region follows as
// 8-byte little-endian words (operation 1); each command starts with a 32-bit
// size that must be at least the minimum, fit the region and be 8-aligned.
// The first error, or acceptance, yields one result transaction carrying a
// status code and an offset; words after that, or with no batch open, give
// no result. A new header abandons any batch in progress.
// Throughput is one transaction per clock while no result is held up. Each
// transaction passes one input register and one result register, with all
// checks in the single logic level between them (34-bit adds and compares,
// one 32x4 constant multiply for the count test). out_stall_i only holds the
// pipeline while a finished result is actually waiting.
// Configuration goes through a 64-bit APB port, registers at 8-byte steps:
//   0x00 memory_size (33 bits), 0x08 expected_version, 0x10 max_batch_bytes,
//   0x18 max_commands. Write them only while the block is idle.
// ----------------------------------------------------------------------------
module command_batch_frame_validator_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire cbfv_pkg::in_item_t            in_data_i,
  // Result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output cbfv_pkg::out_item_t                out_data_o,
  // Configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cbfv_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [cbfv_pkg::CfgDataW-1:0] pwdata,
  output logic      [cbfv_pkg::CfgDataW-1:0] prdata,
  output logic                               pready
);

  cbfv_pkg::cfg_t     cfg;
  logic               item_valid;
  cbfv_pkg::in_item_t item;
  logic               advance;

  cbfv_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stage 1: capture the incoming transaction
  cbfv_in_reg u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // Stage 2: checks, batch state update, result register
  cbfv_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
`default_nettype wire
